### design/planar_chain_forward_kinematics_assert.svh
// Assertion macros for the planar chain forward kinematics block.
`ifndef PLANAR_CHAIN_FORWARD_KINEMATICS_ASSERT_SVH
`define PLANAR_CHAIN_FORWARD_KINEMATICS_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property that holds at every clock edge outside reset.
`define PCFK_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition in one cycle implies a check in the next.
`define PCFK_ASSERT_NEXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`else

`define PCFK_ASSERT(label, prop, msg)
`define PCFK_ASSERT_NEXT(label, cond, expr, msg)

`endif

`endif

### design/pcfk_pkg.sv
`timescale 1ns / 1ps
// Package: sizes, register codes, CORDIC table and saturation for the arm kinematics block.
package pcfk_pkg;

   // Sizing
   localparam int ANGLE_BITS    = 16;
   localparam int COORD_BITS    = 24;
   localparam int CORDIC_STAGES = 16;

   // Beat field widths
   localparam int ANGLE_FIELD_W = 16;
   localparam int LEN_FIELD_W   = 16;
   localparam int OUT_W         = 24;
   localparam int REG_W         = 24;
   localparam int CSR_ADDR_W    = 1;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_BASE_X = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_BASE_Y = 1'd1;

   // Internal formats: turns in 32 bits, vector in Q8.24 with growth headroom
   localparam int TURN_W = 32;
   localparam int XW     = 36;
   localparam int ZW     = 32;
   localparam int DX_W   = XW - 16;
   localparam int PROD_W = LEN_FIELD_W + 30;

   // Gain compensation 0.6072529 in Q0.30
   localparam logic [29:0] GAIN_Q30 = 30'd652032874;

   // Sum width for position update: holds position, step and base plus a carry
   localparam int WIDE_W = (COORD_BITS > OUT_W) ? COORD_BITS : OUT_W;
   localparam int SUM_W  = ((WIDE_W > DX_W) ? WIDE_W : DX_W) + 1;

   localparam logic signed [SUM_W-1:0] COORD_MAX =
      {{(SUM_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] COORD_MIN = ~COORD_MAX;

   // atan(2^-i) in turns, 2^32 = full turn
   localparam logic [TURN_W-1:0] ATAN_TURNS [0:23] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   // Clamp a wide coordinate to the signed position range
   function automatic logic signed [COORD_BITS-1:0] sat_coord(
      input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] c;
      c = v;
      if (v > COORD_MAX) c = COORD_MAX;
      else if (v < COORD_MIN) c = COORD_MIN;
      return c[COORD_BITS-1:0];
   endfunction

endpackage

### design/planar_chain_forward_kinematics.sv
`timescale 1ns / 1ps
// Planar serial arm forward kinematics: takes one link per beat (relative joint angle,
// link length, chain-start flag in req_tuser), adds the angle to a wrapping binary angle
// sum, rotates the link length by that sum with a pipelined, gain-compensated CORDIC and
// adds the rotated vector to the running joint position; each link yields one beat with
// the new joint position in signed Q16.8, saturated. A chain-start link begins again at
// the base point from the csr registers, which are read only at that point. The block
// takes one link per clock cycle while the result side is not stalled; a link passes the
// input register, the gain multiply register, one register per rotation stage and the
// position register. The angle sum is closed at the input and the position sum
// at the output register, so back-to-back links of one chain need no wait.

`include "planar_chain_forward_kinematics_assert.svh"

module planar_chain_forward_kinematics
   import pcfk_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Link beats
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,   // joint_angle[15:0], link_len[31:16]
   input  logic                  req_tuser,   // chain_start
   // Joint position beats
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [47:0]           rsp_tdata,   // joint_x[23:0], joint_y[47:24]
   // Register writes
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [REG_W-1:0]      csr_wdata
);

   // Quadrant codes of the summed angle
   localparam logic [1:0] QUAD_0   = 2'd0;
   localparam logic [1:0] QUAD_90  = 2'd1;
   localparam logic [1:0] QUAD_180 = 2'd2;
   localparam logic [1:0] QUAD_270 = 2'd3;

   localparam int S = CORDIC_STAGES;

   // Input fields
   logic [ANGLE_FIELD_W-1:0] req_joint_angle;
   logic [LEN_FIELD_W-1:0]   req_link_len;
   logic                     req_chain_start;

   assign req_joint_angle = req_tdata[ANGLE_FIELD_W-1:0];
   assign req_link_len    = req_tdata[ANGLE_FIELD_W +: LEN_FIELD_W];
   assign req_chain_start = req_tuser;

   // Config registers
   logic signed [REG_W-1:0] base_x_ff, base_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_x_ff <= '0;
         base_y_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_BASE_X: base_x_ff <= csr_wdata;
            REG_BASE_Y: base_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Handshake and stage readiness
   logic              a_valid_ff;
   logic [S:0]        c_valid_ff;
   logic              rsp_valid_ff;
   logic              out_free;
   logic              out_load;
   logic [S:0]        c_ready;
   logic              a_ready;
   logic              req_fire;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign out_load = out_free && c_valid_ff[S];

   always_comb begin
      c_ready[S] = !c_valid_ff[S] || out_free;
      for (int i = S - 1; i >= 0; i--) begin
         c_ready[i] = !c_valid_ff[i] || c_ready[i+1];
      end
   end

   assign a_ready    = !a_valid_ff || c_ready[0];
   assign req_tready = a_ready;
   assign req_fire   = req_tvalid && a_ready;

   // Running angle sum, closed at the input
   logic [ANGLE_BITS-1:0] angle_sum_ff, angle_sum_in;

   assign angle_sum_in = (req_chain_start ? '0 : angle_sum_ff)
                       + ANGLE_BITS'(req_joint_angle);

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_sum_ff <= '0;
      end else if (req_fire) begin
         angle_sum_ff <= angle_sum_in;
      end
   end

   // Input register
   logic [ANGLE_BITS-1:0]  a_angle_ff;
   logic [LEN_FIELD_W-1:0] a_len_ff;
   logic                   a_start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_angle_ff <= angle_sum_in;
         a_len_ff   <= req_link_len;
         a_start_ff <= req_chain_start;
      end
   end

   // Gain multiply, quadrant split and residual angle
   logic [PROD_W-1:0]      gain_prod;
   logic [TURN_W-1:0]      turn_full;
   logic [TURN_W-1:0]      turn_shift;
   logic signed [XW-1:0]   g_x_in;
   logic signed [ZW-1:0]   g_z_in;
   logic [1:0]             g_quad_in;

   always_comb begin
      gain_prod  = PROD_W'(a_len_ff) * PROD_W'(GAIN_Q30);
      g_x_in     = signed'(XW'(gain_prod[PROD_W-1:14]));
      turn_full  = TURN_W'(a_angle_ff) << (TURN_W - ANGLE_BITS);
      turn_shift = turn_full + 32'h2000_0000;
      g_quad_in  = turn_shift[TURN_W-1:TURN_W-2];
      g_z_in     = signed'({2'b00, turn_shift[TURN_W-3:0]}) - 32'sh2000_0000;
   end

   // Rotation stages: index 0 holds the start vector, index i+1 the result of step i
   logic signed [XW-1:0] cx_ff [0:S];
   logic signed [XW-1:0] cy_ff [0:S];
   logic signed [ZW-1:0] cz_ff [0:S];
   logic [1:0]           cq_ff [0:S];
   logic                 cs_ff [0:S];
   logic signed [XW-1:0] cx_in [1:S];
   logic signed [XW-1:0] cy_in [1:S];
   logic signed [ZW-1:0] cz_in [1:S];

   // One micro-rotation per stage; zero residual counts as positive
   always_comb begin
      for (int i = 0; i < S; i++) begin
         if (!cz_ff[i][ZW-1]) begin
            cx_in[i+1] = cx_ff[i] - (cy_ff[i] >>> i);
            cy_in[i+1] = cy_ff[i] + (cx_ff[i] >>> i);
            cz_in[i+1] = cz_ff[i] - signed'(ZW'(ATAN_TURNS[i]));
         end else begin
            cx_in[i+1] = cx_ff[i] + (cy_ff[i] >>> i);
            cy_in[i+1] = cy_ff[i] - (cx_ff[i] >>> i);
            cz_in[i+1] = cz_ff[i] + signed'(ZW'(ATAN_TURNS[i]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= '0;
      end else begin
         if (c_ready[0]) c_valid_ff[0] <= a_valid_ff;
         for (int i = 1; i <= S; i++) begin
            if (c_ready[i]) c_valid_ff[i] <= c_valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (c_ready[0]) begin
         cx_ff[0] <= g_x_in;
         cy_ff[0] <= '0;
         cz_ff[0] <= g_z_in;
         cq_ff[0] <= g_quad_in;
         cs_ff[0] <= a_start_ff;
      end
      for (int i = 1; i <= S; i++) begin
         if (c_ready[i]) begin
            cx_ff[i] <= cx_in[i];
            cy_ff[i] <= cy_in[i];
            cz_ff[i] <= cz_in[i];
            cq_ff[i] <= cq_ff[i-1];
            cs_ff[i] <= cs_ff[i-1];
         end
      end
   end

   // Quadrant fix-up, round half up to Q8.8, position add with saturation
   logic signed [XW-1:0]         rot_x, rot_y;
   logic signed [XW-1:0]         rnd_x, rnd_y;
   logic signed [DX_W-1:0]       dx, dy;
   logic signed [SUM_W-1:0]      prev_x, prev_y;
   logic signed [SUM_W-1:0]      sum_x, sum_y;
   logic signed [COORD_BITS-1:0] pos_x_ff, pos_y_ff;
   logic signed [COORD_BITS-1:0] pos_x_in, pos_y_in;

   always_comb begin
      unique case (cq_ff[S])
         QUAD_0: begin
            rot_x = cx_ff[S];
            rot_y = cy_ff[S];
         end
         QUAD_90: begin
            rot_x = -cy_ff[S];
            rot_y = cx_ff[S];
         end
         QUAD_180: begin
            rot_x = -cx_ff[S];
            rot_y = -cy_ff[S];
         end
         QUAD_270: begin
            rot_x = cy_ff[S];
            rot_y = -cx_ff[S];
         end
         default: begin
            rot_x = cx_ff[S];
            rot_y = cy_ff[S];
         end
      endcase
      rnd_x = rot_x + XW'(32'sh8000);
      rnd_y = rot_y + XW'(32'sh8000);
      dx    = DX_W'(rnd_x >>> 16);
      dy    = DX_W'(rnd_y >>> 16);

      prev_x = cs_ff[S] ? SUM_W'(sat_coord(SUM_W'(base_x_ff))) : SUM_W'(pos_x_ff);
      prev_y = cs_ff[S] ? SUM_W'(sat_coord(SUM_W'(base_y_ff))) : SUM_W'(pos_y_ff);
      sum_x  = prev_x + SUM_W'(dx);
      sum_y  = prev_y + SUM_W'(dy);
      pos_x_in = sat_coord(sum_x);
      pos_y_in = sat_coord(sum_y);
   end

   // Position state doubles as the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
      end else begin
         if (out_free) rsp_valid_ff <= c_valid_ff[S];
         if (out_load) begin
            pos_x_ff <= pos_x_in;
            pos_y_ff <= pos_y_in;
         end
      end
   end

   // Result beat: low bits of the positions, sign-extended when narrower
   logic signed [WIDE_W-1:0] pos_x_ext, pos_y_ext;

   assign pos_x_ext  = WIDE_W'(pos_x_ff);
   assign pos_y_ext  = WIDE_W'(pos_y_ff);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {pos_y_ext[OUT_W-1:0], pos_x_ext[OUT_W-1:0]};

   // Checks
   `PCFK_ASSERT_NEXT(a_pos_hold, !out_load, $stable(pos_x_ff) && $stable(pos_y_ff), "position changed with no link arriving")
   `PCFK_ASSERT_NEXT(a_chain_restart, req_fire && req_chain_start, angle_sum_ff == ANGLE_BITS'($past(req_joint_angle)), "angle sum not restarted by chain start")
   `PCFK_ASSERT(a_empty_ready, !a_valid_ff |-> req_tready, "input stage empty but not ready")
   `PCFK_ASSERT_NEXT(a_no_phantom, (c_valid_ff == '0) && !rsp_valid_ff, !rsp_valid_ff, "result appeared from an empty pipeline")

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the planar chain forward kinematics block: directed and random link beats.
module tb_top;
   import pcfk_pkg::*;

   localparam logic [1:0] QUAD_0   = 2'd0;
   localparam logic [1:0] QUAD_90  = 2'd1;
   localparam logic [1:0] QUAD_180 = 2'd2;
   localparam logic [1:0] QUAD_270 = 2'd3;

   localparam longint COORD_HI = (64'sd1 <<< (COORD_BITS - 1)) - 1;
   localparam longint COORD_LO = -COORD_HI - 1;
   localparam int RANDOM_LINKS = 950;

   typedef struct packed {
      logic [OUT_W-1:0] jy;
      logic [OUT_W-1:0] jx;
   } joint_pos_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [31:0]           req_tdata = '0;    // joint_angle[15:0], link_len[31:16]
   logic                  req_tuser = 1'b0;  // chain_start
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [47:0]           rsp_tdata;         // joint_x[23:0], joint_y[47:24]
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [REG_W-1:0]      csr_wdata = '0;

   // Arm state mirrored from the block
   longint                base_x_val = 0;
   longint                base_y_val = 0;
   logic [ANGLE_BITS-1:0] heading = '0;
   longint                arm_x = 0;
   longint                arm_y = 0;
   joint_pos_type         joint_pos_q[$];

   int errors = 0;
   bit req_burst = 1'b0;
   bit rsp_burst = 1'b0;

   planar_chain_forward_kinematics uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // Clock
   initial begin
      forever #10 clock = ~clock;
   end

   // Rotate a link of length len by the heading; returns the Q8.8 step
   function automatic void link_rotate(input logic [ANGLE_BITS-1:0] ang,
                                       input logic [15:0] len,
                                       output longint step_x, output longint step_y);
      logic [31:0] turn;
      logic [1:0]  quad;
      longint      z, vx, vy, sx, sy, rx, ry;
      turn = {ang, {(32 - ANGLE_BITS){1'b0}}} + 32'h2000_0000;
      quad = turn[31:30];
      z    = longint'(turn[29:0]) - 64'sd536870912;
      vx   = (longint'(len) * longint'(GAIN_Q30)) >>> 14;
      vy   = 0;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         sx = vx >>> i;
         sy = vy >>> i;
         if (z >= 0) begin
            vx = vx - sy;
            vy = vy + sx;
            z  = z - longint'(ATAN_TURNS[i]);
         end else begin
            vx = vx + sy;
            vy = vy - sx;
            z  = z + longint'(ATAN_TURNS[i]);
         end
      end
      // exact quadrant fold
      unique case (quad)
         QUAD_0: begin
            rx = vx;
            ry = vy;
         end
         QUAD_90: begin
            rx = -vy;
            ry = vx;
         end
         QUAD_180: begin
            rx = -vx;
            ry = -vy;
         end
         QUAD_270: begin
            rx = vy;
            ry = -vx;
         end
      endcase
      // round half up to Q8.8
      step_x = (rx + 32768) >>> 16;
      step_y = (ry + 32768) >>> 16;
   endfunction

   function automatic longint clamp_coord(input longint v);
      if (v > COORD_HI) return COORD_HI;
      if (v < COORD_LO) return COORD_LO;
      return v;
   endfunction

   // Advance the mirrored arm by one accepted link and queue the joint position
   function automatic void advance_chain(input logic [15:0] angle, input logic [15:0] len,
                                         input logic start);
      longint        step_x, step_y;
      joint_pos_type p;
      if (start) begin
         heading = '0;
         arm_x   = clamp_coord(base_x_val);
         arm_y   = clamp_coord(base_y_val);
      end
      heading = heading + angle[ANGLE_BITS-1:0];
      link_rotate(heading, len, step_x, step_y);
      arm_x = clamp_coord(arm_x + step_x);
      arm_y = clamp_coord(arm_y + step_y);
      p.jx  = arm_x[OUT_W-1:0];
      p.jy  = arm_y[OUT_W-1:0];
      joint_pos_q = {joint_pos_q, p};
   endfunction

   // Send one link beat after a random gap, or at once in burst mode
   task automatic send_link(input logic [15:0] angle, input logic [15:0] len,
                            input logic start);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {len, angle};
      req_tuser  <= start;
      do @(posedge clock); while (!req_tready);
      advance_chain(angle, len, start);
   endtask

   // Stop sending and let the pipeline empty
   task automatic drain_links();
      req_tvalid <= 1'b0;
      wait (joint_pos_q.size() == 0);
      repeat (CORDIC_STAGES + 6) @(posedge clock);
   endtask

   // Register write; call only while idle
   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [REG_W-1:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      if (idx == REG_BASE_X) base_x_val = longint'($signed(val));
      else if (idx == REG_BASE_Y) base_y_val = longint'($signed(val));
   endtask

   // Result side: random stalls, with burst stretches
   initial begin : rsp_stall
      int gap;
      @(posedge clock iff !reset);
      forever begin
         gap = rsp_burst ? 0 : $urandom_range(0, 16);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Compare each joint position beat with the oldest prediction
   always @(posedge clock) begin : check_joint
      joint_pos_type want;
      joint_pos_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (joint_pos_q.size() == 0) begin
            $display("%0t: unexpected joint beat, actual x=%h y=%h", $time, got.jx, got.jy);
            errors++;
         end else begin
            want = joint_pos_q.pop_front();
            if (got.jx !== want.jx) begin
               $display("%0t: joint_x mismatch, expected %h actual %h",
                        $time, want.jx, got.jx);
               errors++;
            end
            if (got.jy !== want.jy) begin
               $display("%0t: joint_y mismatch, expected %h actual %h",
                        $time, want.jy, got.jy);
               errors++;
            end
         end
      end
   end

   // Links before any chain start run from the reset base
   task automatic test_reset_state();
      send_link(16'h0000, 16'h0100, 1'b0);
      send_link(16'h1234, 16'h0280, 1'b0);
   endtask

   // Angle extremes, octant edges, wrap of the sum, length extremes
   task automatic test_angle_extremes();
      send_link(16'h0000, 16'hFFFF, 1'b1);
      send_link(16'hFFFF, 16'h0000, 1'b0);
      send_link(16'h0001, 16'h0001, 1'b0);
      send_link(16'h2000, 16'h0100, 1'b1);
      send_link(16'hFFFF, 16'h0100, 1'b0);
      send_link(16'h4000, 16'hFFFF, 1'b1);
      send_link(16'h4000, 16'hFFFF, 1'b0);
      send_link(16'h4000, 16'hFFFF, 1'b0);
      send_link(16'h6000, 16'h8000, 1'b0);
      send_link(16'hE000, 16'h7FFF, 1'b1);
      send_link(16'h9FFF, 16'h1234, 1'b0);
      send_link(16'hFFFF, 16'hFFFF, 1'b1);
   endtask

   // Positions clamp at both ends of the coordinate range
   task automatic test_saturation();
      drain_links();
      write_reg(REG_BASE_X, 24'h7FFF00);
      write_reg(REG_BASE_Y, 24'h800100);
      send_link(16'h0000, 16'hFFFF, 1'b1);
      send_link(16'hC000, 16'hFFFF, 1'b0);
      send_link(16'h4000, 16'hFFFF, 1'b0);
      drain_links();
      write_reg(REG_BASE_X, 24'h800000);
      write_reg(REG_BASE_Y, 24'h7FFFFF);
      send_link(16'h8000, 16'hFFFF, 1'b1);
      send_link(16'hC000, 16'hFFFF, 1'b0);
   endtask

   // New base values wait for the next chain start
   task automatic test_deferred_base();
      drain_links();
      write_reg(REG_BASE_X, 24'h001000);
      write_reg(REG_BASE_Y, 24'hFFF000);
      send_link(16'h0800, 16'h0300, 1'b0);
      send_link(16'h0100, 16'h0200, 1'b1);
      send_link(16'h0100, 16'h0200, 1'b0);
   endtask

   // Random arms: mostly well formed chains, some without a start beat
   task automatic test_random_chains();
      int          sent, phase, in_phase, links;
      bit          broken;
      logic [15:0] ang, len;
      logic        st;
      logic [23:0] bx, by;
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_LINKS) begin
         drain_links();
         case (phase % 4)
            0: begin
               bx = 24'($urandom());
               by = 24'($urandom());
            end
            1: begin
               bx = 24'h7FFFFF;
               by = 24'h800000;
            end
            2: begin
               bx = 24'h800000;
               by = 24'h7FFFFF;
            end
            default: begin
               bx = 24'($urandom_range(0, 16'hFFFF));
               by = 24'(-$urandom_range(0, 16'hFFFF));
            end
         endcase
         write_reg(REG_BASE_X, bx);
         write_reg(REG_BASE_Y, by);
         req_burst = ($urandom_range(0, 3) == 0);
         rsp_burst = ($urandom_range(0, 3) == 0);
         in_phase  = 0;
         while (in_phase < 150 && sent < RANDOM_LINKS) begin
            links  = $urandom_range(1, 16);
            broken = ($urandom_range(0, 9) == 0);
            for (int k = 0; k < links; k++) begin
               case ($urandom_range(0, 3))
                  0: ang = 16'($urandom_range(0, 16'hFFFF));
                  1: ang = 16'($urandom_range(0, 255));
                  2: ang = 16'(-$urandom_range(0, 255));
                  default: ang = 16'(($urandom_range(0, 7) << 13)
                                     + $urandom_range(0, 2) - 1);
               endcase
               case ($urandom_range(0, 3))
                  0: len = 16'($urandom_range(0, 1023));
                  1: len = 16'($urandom_range(16'hFF00, 16'hFFFF));
                  default: len = 16'($urandom_range(0, 16'hFFFF));
               endcase
               st = (k == 0) ? !broken : ($urandom_range(0, 19) == 0);
               send_link(ang, len, st);
               sent++;
               in_phase++;
            end
         end
         phase++;
      end
   endtask

   // Main sequence
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_angle_extremes();
      test_saturation();
      test_deferred_base();
      test_random_chains();
      drain_links();
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(20_000_000);
      $display("Simulation FAILED");
      $finish;
   end

endmodule

### sim.f
+incdir+design
design/pcfk_pkg.sv
design/planar_chain_forward_kinematics.sv
verif/tb_top.sv
